[rtl/core/i2cseq_pkg.sv]
package i2cseq_pkg;

   localparam int MAX_BYTES_DEFAULT = 4;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // count field of a command; wide enough for the largest byte limit
   localparam int COUNT_W = 4;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ = 2'd1;
   localparam logic [1:0] OP_RX = 2'd2;

   localparam logic [2:0] ACT_START = 3'd0;
   localparam logic [2:0] ACT_SEND = 3'd1;
   localparam logic [2:0] ACT_READ = 3'd2;
   localparam logic [2:0] ACT_STOP = 3'd3;
   localparam logic [2:0] ACT_DONE = 3'd4;

   localparam logic [7:0] DEV_WRITE = 8'hA0;
   localparam logic [7:0] DEV_READ = 8'hA1;

   typedef struct packed {
      logic [1:0] op;
      logic [15:0] address;
      logic [31:0] write_data;
      logic [2:0] length;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] bus_byte;
      logic [31:0] read_value;
      logic last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_READ,
      CMD_DONE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic stop_first;
      logic [15:0] address;
      logic [31:0] data;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/core/i2cseq_front.sv]
module i2cseq_front #(
   parameter int MAX_BYTES = i2cseq_pkg::MAX_BYTES_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input i2cseq_pkg::req_type req_data,
   input i2cseq_pkg::queue_status_type status,
   output logic push,
   output i2cseq_pkg::cmd_type push_cmd
);

   localparam int CNT_W = $clog2(MAX_BYTES + 1);

   logic read_pending_ff, read_pending_in;
   logic [15:0] next_address_ff, next_address_in;
   logic [CNT_W-1:0] bytes_left_ff, bytes_left_in;
   logic [31:0] accumulator_ff, accumulator_in;

   logic accept;
   logic [CNT_W-1:0] len_sat;
   logic [CNT_W-1:0] left_dec;

   assign req_stall = status.full;
   assign accept = req_valid && !status.full;

   always_comb begin
      if (32'(req_data.length) > MAX_BYTES) begin
         len_sat = CNT_W'(MAX_BYTES);
      end else begin
         len_sat = CNT_W'(req_data.length);
      end
   end

   always_comb begin
      read_pending_in = read_pending_ff;
      next_address_in = next_address_ff;
      bytes_left_in = bytes_left_ff;
      accumulator_in = accumulator_ff;
      left_dec = bytes_left_ff;
      push = 1'b0;
      push_cmd = '0;
      if (accept) begin
         unique case (req_data.op)
            i2cseq_pkg::OP_WRITE: begin
               read_pending_in = 1'b0;
               push = 1'b1;
               push_cmd.kind = i2cseq_pkg::CMD_WRITE;
               push_cmd.address = req_data.address;
               push_cmd.data = req_data.write_data;
               push_cmd.count = i2cseq_pkg::COUNT_W'(len_sat);
            end
            i2cseq_pkg::OP_READ: begin
               read_pending_in = 1'b0;
               accumulator_in = '0;
               push = 1'b1;
               if (len_sat == '0) begin
                  push_cmd.kind = i2cseq_pkg::CMD_DONE;
               end else begin
                  // highest address first
                  next_address_in = req_data.address + 16'(len_sat) - 16'd1;
                  bytes_left_in = len_sat;
                  read_pending_in = 1'b1;
                  push_cmd.kind = i2cseq_pkg::CMD_READ;
                  push_cmd.address = next_address_in;
               end
            end
            i2cseq_pkg::OP_RX: begin
               if (read_pending_ff) begin
                  accumulator_in = {accumulator_ff[23:0], req_data.rx_byte};
                  if (bytes_left_ff != '0) begin
                     left_dec = bytes_left_ff - CNT_W'(1);
                  end
                  bytes_left_in = left_dec;
                  push = 1'b1;
                  push_cmd.stop_first = 1'b1;
                  if (left_dec != '0) begin
                     next_address_in = next_address_ff - 16'd1;
                     push_cmd.kind = i2cseq_pkg::CMD_READ;
                     push_cmd.address = next_address_in;
                  end else begin
                     read_pending_in = 1'b0;
                     push_cmd.kind = i2cseq_pkg::CMD_DONE;
                     push_cmd.data = accumulator_in;
                  end
               end
            end
            default: begin
               // drop undefined op
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_pending_ff <= 1'b0;
         next_address_ff <= '0;
         bytes_left_ff <= '0;
         accumulator_ff <= '0;
      end else begin
         read_pending_ff <= read_pending_in;
         next_address_ff <= next_address_in;
         bytes_left_ff <= bytes_left_in;
         accumulator_ff <= accumulator_in;
      end
   end

endmodule

[rtl/core/i2cseq_cmd_queue.sv]
module i2cseq_cmd_queue #(
   parameter int DEPTH = i2cseq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic push,
   input i2cseq_pkg::cmd_type push_cmd,
   input logic pop,
   output i2cseq_pkg::cmd_type pop_cmd,
   output i2cseq_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   i2cseq_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0] count_ff, count_in;
   logic do_push, do_pop;

   assign status.full = (count_ff == (PTR_W + 1)'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push && !status.full;
   assign do_pop = pop && !status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + (PTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (PTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/i2cseq_back.sv]
module i2cseq_back (
   input logic clock,
   input logic reset,
   input logic two_byte_address,
   input i2cseq_pkg::queue_status_type status,
   output logic pop,
   input i2cseq_pkg::cmd_type pop_cmd,
   output logic rsp_valid,
   input logic rsp_stall,
   output i2cseq_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_PRE_STOP,
      PH_START,
      PH_DEV,
      PH_HIGH,
      PH_LOW,
      PH_DATA,
      PH_STOP,
      PH_RSTART,
      PH_RDEV,
      PH_READ,
      PH_DONE
   } phase_type;

   phase_type phase_ff, phase_in, phase_adv;
   i2cseq_pkg::cmd_kind_type kind_ff, kind_in;
   logic [15:0] addr_ff, addr_in;
   logic [31:0] data_ff, data_in;
   logic [i2cseq_pkg::COUNT_W-1:0] left_ff, left_in;
   logic rsp_valid_ff, rsp_valid_in;
   i2cseq_pkg::rsp_type rsp_data_ff, rsp_data_in;
   i2cseq_pkg::rsp_type out_rsp;
   logic can_emit;

   function automatic logic [7:0] dev_byte(input logic [7:0] base, input logic [15:0] addr,
                                           input logic two);
      logic [7:0] result;
      result = base;
      if (!two) begin
         result = base | {4'd0, addr[10:8], 1'b0};
      end
      return result;
   endfunction

   assign can_emit = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   // action and successor of the current phase
   always_comb begin
      out_rsp = '0;
      phase_adv = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            phase_adv = PH_IDLE;
         end
         PH_PRE_STOP: begin
            out_rsp.action = i2cseq_pkg::ACT_STOP;
            phase_adv = (kind_ff == i2cseq_pkg::CMD_READ) ? PH_START : PH_DONE;
         end
         PH_START: begin
            out_rsp.action = i2cseq_pkg::ACT_START;
            phase_adv = PH_DEV;
         end
         PH_DEV: begin
            out_rsp.action = i2cseq_pkg::ACT_SEND;
            out_rsp.bus_byte = dev_byte(i2cseq_pkg::DEV_WRITE, addr_ff, two_byte_address);
            phase_adv = two_byte_address ? PH_HIGH : PH_LOW;
         end
         PH_HIGH: begin
            out_rsp.action = i2cseq_pkg::ACT_SEND;
            out_rsp.bus_byte = addr_ff[15:8];
            phase_adv = PH_LOW;
         end
         PH_LOW: begin
            out_rsp.action = i2cseq_pkg::ACT_SEND;
            out_rsp.bus_byte = addr_ff[7:0];
            phase_adv = (kind_ff == i2cseq_pkg::CMD_WRITE) ? PH_DATA : PH_RSTART;
         end
         PH_DATA: begin
            out_rsp.action = i2cseq_pkg::ACT_SEND;
            out_rsp.bus_byte = data_ff[7:0];
            phase_adv = PH_STOP;
         end
         PH_STOP: begin
            out_rsp.action = i2cseq_pkg::ACT_STOP;
            phase_adv = (left_ff > i2cseq_pkg::COUNT_W'(1)) ? PH_START : PH_DONE;
         end
         PH_RSTART: begin
            out_rsp.action = i2cseq_pkg::ACT_START;
            phase_adv = PH_RDEV;
         end
         PH_RDEV: begin
            out_rsp.action = i2cseq_pkg::ACT_SEND;
            out_rsp.bus_byte = dev_byte(i2cseq_pkg::DEV_READ, addr_ff, two_byte_address);
            phase_adv = PH_READ;
         end
         PH_READ: begin
            out_rsp.action = i2cseq_pkg::ACT_READ;
            out_rsp.last = 1'b1;
            phase_adv = PH_IDLE;
         end
         PH_DONE: begin
            out_rsp.action = i2cseq_pkg::ACT_DONE;
            out_rsp.read_value = (kind_ff == i2cseq_pkg::CMD_DONE) ? data_ff : 32'd0;
            out_rsp.last = 1'b1;
            phase_adv = PH_IDLE;
         end
         default: begin
            phase_adv = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      kind_in = kind_ff;
      addr_in = addr_ff;
      data_in = data_ff;
      left_in = left_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      pop = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (!status.empty) begin
            pop = 1'b1;
            kind_in = pop_cmd.kind;
            addr_in = pop_cmd.address;
            data_in = pop_cmd.data;
            left_in = pop_cmd.count;
            unique case (pop_cmd.kind)
               i2cseq_pkg::CMD_WRITE: begin
                  phase_in = (pop_cmd.count == '0) ? PH_DONE : PH_START;
               end
               i2cseq_pkg::CMD_READ: begin
                  phase_in = pop_cmd.stop_first ? PH_PRE_STOP : PH_START;
               end
               i2cseq_pkg::CMD_DONE: begin
                  phase_in = pop_cmd.stop_first ? PH_PRE_STOP : PH_DONE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end else if (can_emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = out_rsp;
         phase_in = phase_adv;
         // advance to the next byte of a write
         if (phase_ff == PH_STOP && left_ff > i2cseq_pkg::COUNT_W'(1)) begin
            left_in = left_ff - i2cseq_pkg::COUNT_W'(1);
            addr_in = addr_ff + 16'd1;
            data_in = {8'd0, data_ff[31:8]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      addr_ff <= addr_in;
      data_ff <= data_in;
      left_ff <= left_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[rtl/core/i2c_eeprom_access_sequencer.sv]
// Master-side sequencer for a 24Cxx-style I2C EEPROM.
// req channel: op 0 writes length bytes of write_data from address upward, op 1
// reads length bytes from the highest address down, op 2 hands back the byte a
// bus read returned. Other items (op 3, op 2 with no read open) are dropped.
// rsp channel: one bus action per item (start, send byte, read byte, stop,
// done); last marks the final action caused by a req item, and done of a read
// carries the assembled value.
// csr port: csr_wr_en writes csr_wr_data into the two-byte-address mode bit;
// write it only while no request is in flight.
// Flow: a command passes from its taken req item through the queue entry and the
// sequencer phase register into the rsp register; then one action per cycle while
// rsp_stall is low. A write of N bytes gives 5N+1 actions (6N+1 in two-byte mode),
// a read step up to 8; the sequencer adds an idle phase to take each command.
// The classifier takes req items as long as the command queue has room, so
// req_stall rises once QUEUE_DEPTH commands wait, whether the sequencer is held
// by a stalled rsp or still busy with the actions of earlier commands.
// Reset (synchronous) clears the queue, the open read and the mode bit; rsp_valid
// drops in the next cycle. A stalled rsp item holds until taken.
module i2c_eeprom_access_sequencer #(
   parameter int MAX_BYTES = i2cseq_pkg::MAX_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH = i2cseq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input i2cseq_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output i2cseq_pkg::rsp_type rsp_data,
   input logic csr_wr_en,
   input logic csr_wr_data
);

   logic two_byte_address_ff;
   logic push, pop;
   i2cseq_pkg::cmd_type push_cmd, pop_cmd;
   i2cseq_pkg::queue_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         two_byte_address_ff <= 1'b0;
      end else if (csr_wr_en) begin
         two_byte_address_ff <= csr_wr_data;
      end
   end

   i2cseq_front #(
      .MAX_BYTES(MAX_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .status(status),
      .push(push),
      .push_cmd(push_cmd)
   );

   i2cseq_cmd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .pop(pop),
      .pop_cmd(pop_cmd),
      .status(status)
   );

   i2cseq_back u_back (
      .clock(clock),
      .reset(reset),
      .two_byte_address(two_byte_address_ff),
      .status(status),
      .pop(pop),
      .pop_cmd(pop_cmd),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

endmodule

[rtl/core/i2cseq_checker.sv]
module i2cseq_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_stall,
   input i2cseq_pkg::rsp_type rsp_data
);

   // hold a stalled item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.action == i2cseq_pkg::ACT_DONE ||
                    rsp_data.action == i2cseq_pkg::ACT_READ) |-> rsp_data.last)
      else $error("done or read without last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != i2cseq_pkg::ACT_SEND |-> rsp_data.bus_byte == 8'd0)
      else $error("bus byte set on a non-send action");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != i2cseq_pkg::ACT_DONE |->
         rsp_data.read_value == 32'd0 && !rsp_data.last ||
         rsp_data.action == i2cseq_pkg::ACT_READ)
      else $error("value or last on an intermediate action");

endmodule

bind i2c_eeprom_access_sequencer i2cseq_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data(rsp_data)
);
